/* design/tkd_pkg.sv */
`timescale 1ns / 1ps

package tkd_pkg;

   typedef logic [1:0] key_code_type;
   typedef logic [1:0] key_pins_type;
   typedef logic [7:0] tick_count_type;

   localparam key_code_type CODE_NONE   = 2'd0;
   localparam key_code_type CODE_FIRST  = 2'd1;
   localparam key_code_type CODE_SECOND = 2'd2;

   localparam key_pins_type PINS_RELEASED = 2'b11;
   localparam key_pins_type PINS_FIRST    = 2'b10;
   localparam key_pins_type PINS_SECOND   = 2'b01;

   localparam tick_count_type DEBOUNCE_TICKS_RESET = 8'd20;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register index is the word address, taken from the top address bit.
   localparam logic REG_DEBOUNCE_TICKS = 1'b0;

   function automatic key_code_type decode_pins(input key_pins_type pins);
      key_code_type code;
      case (pins)
         PINS_FIRST: begin
            code = CODE_FIRST;
         end
         PINS_SECOND: begin
            code = CODE_SECOND;
         end
         default: begin
            code = CODE_NONE;
         end
      endcase
      return code;
   endfunction

endpackage

/* design/tkd_csr.sv */
`timescale 1ns / 1ps

module tkd_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [tkd_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [tkd_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [tkd_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                   pready,
   output tkd_pkg::tick_count_type                debounce_ticks
);

   tkd_pkg::tick_count_type debounce_ticks_ff;
   tkd_pkg::tick_count_type debounce_ticks_in;
   logic                    write_hit;
   logic                    read_hit;

   assign pready    = 1'b1;
   assign read_hit  = (paddr[tkd_pkg::CSR_ADDR_WIDTH-1] == tkd_pkg::REG_DEBOUNCE_TICKS);
   assign write_hit = psel && penable && pwrite && pready && read_hit;

   always_comb begin
      debounce_ticks_in = debounce_ticks_ff;
      if (write_hit) begin
         debounce_ticks_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= tkd_pkg::DEBOUNCE_TICKS_RESET;
      end else begin
         debounce_ticks_ff <= debounce_ticks_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (read_hit) begin
         prdata = {{(tkd_pkg::CSR_DATA_WIDTH-8){1'b0}}, debounce_ticks_ff};
      end
   end

   assign debounce_ticks = debounce_ticks_ff;

endmodule

/* design/tkd_scan.sv */
`timescale 1ns / 1ps

module tkd_scan (
   input  logic                    clock,
   input  logic                    reset,
   input  tkd_pkg::tick_count_type debounce_ticks,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tkd_pkg::key_pins_type   req_key_pins,
   input  logic                    req_take_first,
   input  logic                    req_take_second,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tkd_pkg::key_code_type   rsp_held_key,
   output logic                    rsp_any_pressed,
   output logic                    rsp_first_taken,
   output logic                    rsp_second_taken
);

   logic                    release_armed_ff;
   logic                    release_armed_in;
   tkd_pkg::tick_count_type release_count_ff;
   tkd_pkg::tick_count_type release_count_in;
   tkd_pkg::tick_count_type press_count_ff;
   tkd_pkg::tick_count_type press_count_in;
   tkd_pkg::key_code_type   last_code_ff;
   tkd_pkg::key_code_type   last_code_in;
   tkd_pkg::key_code_type   held_code_ff;
   tkd_pkg::key_code_type   held_code_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   tkd_pkg::key_code_type   rsp_held_key_ff;
   logic                    rsp_any_pressed_ff;
   logic                    rsp_first_taken_ff;
   logic                    rsp_second_taken_ff;

   logic                    accept;
   logic                    pressed;
   tkd_pkg::key_code_type   code;
   tkd_pkg::key_code_type   scan_held;
   tkd_pkg::tick_count_type release_next;
   tkd_pkg::tick_count_type press_next;
   logic                    got_first;
   logic                    got_second;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pressed   = (req_key_pins != tkd_pkg::PINS_RELEASED);
   assign code      = tkd_pkg::decode_pins(req_key_pins);

   assign release_next = release_count_ff + 8'd1;
   assign press_next   = press_count_ff + 8'd1;

   always_comb begin
      release_armed_in = release_armed_ff;
      release_count_in = release_count_ff;
      press_count_in   = press_count_ff;
      last_code_in     = last_code_ff;
      scan_held        = held_code_ff;

      if (pressed) begin
         release_count_in = '0;
         if (code != last_code_ff) begin
            last_code_in   = code;
            press_count_in = '0;
         end else if (press_next >= debounce_ticks) begin
            press_count_in = '0;
            if (release_armed_ff) begin
               scan_held = code;
               if (code != tkd_pkg::CODE_NONE) begin
                  release_armed_in = 1'b0;
               end
            end
         end else begin
            press_count_in = press_next;
         end
      end else begin
         press_count_in = '0;
         if (release_next >= debounce_ticks) begin
            release_count_in = '0;
            release_armed_in = 1'b1;
            scan_held        = tkd_pkg::CODE_NONE;
         end else begin
            release_count_in = release_next;
         end
      end

      got_first    = req_take_first && (scan_held == tkd_pkg::CODE_FIRST);
      got_second   = req_take_second && (scan_held == tkd_pkg::CODE_SECOND);
      held_code_in = (got_first || got_second) ? tkd_pkg::CODE_NONE : scan_held;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_armed_ff <= 1'b0;
         release_count_ff <= '0;
         press_count_ff   <= '0;
         last_code_ff     <= tkd_pkg::CODE_NONE;
         held_code_ff     <= tkd_pkg::CODE_NONE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            release_armed_ff <= release_armed_in;
            release_count_ff <= release_count_in;
            press_count_ff   <= press_count_in;
            last_code_ff     <= last_code_in;
            held_code_ff     <= held_code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_held_key_ff     <= held_code_in;
         rsp_any_pressed_ff  <= pressed;
         rsp_first_taken_ff  <= got_first;
         rsp_second_taken_ff <= got_second;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_held_key     = rsp_held_key_ff;
   assign rsp_any_pressed  = rsp_any_pressed_ff;
   assign rsp_first_taken  = rsp_first_taken_ff;
   assign rsp_second_taken = rsp_second_taken_ff;

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("Accepted word produced no result word.");

   a_single_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_first_taken && rsp_second_taken))
      else $error("Both takes reported in one word.");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_first_taken || rsp_second_taken)
         |-> rsp_held_key == tkd_pkg::CODE_NONE)
      else $error("A taken code is still held.");

   a_held_matches_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_held_key == held_code_ff)
      else $error("Result word disagrees with the held code.");

   a_armed_held_none: assert property (@(posedge clock) disable iff (reset)
      accept && !pressed && (release_next >= debounce_ticks)
         |=> release_armed_ff && held_code_ff == tkd_pkg::CODE_NONE)
      else $error("Debounced release did not arm and clear.");

endmodule

/* design/two_key_debouncer_unit.sv */
`timescale 1ns / 1ps

// Channel  Handshake                 Payload
// req      req_valid / req_ready     req_key_pins, req_take_first, req_take_second
// rsp      rsp_valid / rsp_ready     rsp_held_key, rsp_any_pressed, rsp_first_taken,
//                                    rsp_second_taken
// csr      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// The scan and take logic updates the debounce state at acceptance, and the result word
// appears in the output register on the next cycle.
// A new word is accepted every cycle while the output register is empty or being drained.
// When rsp_ready is low the result holds and req_ready drops until it is taken.
// Reset is synchronous; it clears the counters, flags and held code, and restores
// debounce_ticks to 20. No clearing pass is needed after reset.

module two_key_debouncer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_key_pins,
   input  logic                                   req_take_first,
   input  logic                                   req_take_second,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_held_key,
   output logic                                   rsp_any_pressed,
   output logic                                   rsp_first_taken,
   output logic                                   rsp_second_taken,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [tkd_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [tkd_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [tkd_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                   pready
);

   tkd_pkg::tick_count_type debounce_ticks;

   tkd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .debounce_ticks (debounce_ticks)
   );

   tkd_scan u_scan (
      .clock            (clock),
      .reset            (reset),
      .debounce_ticks   (debounce_ticks),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_pins     (req_key_pins),
      .req_take_first   (req_take_first),
      .req_take_second  (req_take_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_held_key     (rsp_held_key),
      .rsp_any_pressed  (rsp_any_pressed),
      .rsp_first_taken  (rsp_first_taken),
      .rsp_second_taken (rsp_second_taken)
   );

endmodule

/* bench/two_key_debouncer_unit_tb.sv */
`timescale 1ns / 1ps

module two_key_debouncer_unit_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam tkd_pkg::key_pins_type PINS_BOTH = 2'b00;

   typedef struct packed {
      tkd_pkg::key_code_type held_key;
      logic                  any_pressed;
      logic                  first_taken;
      logic                  second_taken;
   } key_outcome_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   tkd_pkg::key_pins_type              req_key_pins = tkd_pkg::PINS_RELEASED;
   logic                               req_take_first = 1'b0;
   logic                               req_take_second = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [1:0]                         rsp_held_key;
   logic                               rsp_any_pressed;
   logic                               rsp_first_taken;
   logic                               rsp_second_taken;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [tkd_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [tkd_pkg::CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [tkd_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                               pready;

   key_outcome_type pending_outcomes[$];
   key_outcome_type oldest_outcome;
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   logic            req_idling = 1'b1;
   logic            rsp_idling = 1'b1;

   // Shadow of the debounce state, updated as each word is accepted.
   tkd_pkg::tick_count_type debounce_limit = tkd_pkg::DEBOUNCE_TICKS_RESET;
   tkd_pkg::tick_count_type idle_ticks = '0;
   tkd_pkg::tick_count_type stable_ticks = '0;
   logic                    armed_by_release = 1'b0;
   tkd_pkg::key_code_type   seen_code = tkd_pkg::CODE_NONE;
   tkd_pkg::key_code_type   latched_code = tkd_pkg::CODE_NONE;

   two_key_debouncer_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_pins     (req_key_pins),
      .req_take_first   (req_take_first),
      .req_take_second  (req_take_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_held_key     (rsp_held_key),
      .rsp_any_pressed  (rsp_any_pressed),
      .rsp_first_taken  (rsp_first_taken),
      .rsp_second_taken (rsp_second_taken),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic key_outcome_type scan_and_take(input tkd_pkg::key_pins_type pins,
                                                     input logic take_first,
                                                     input logic take_second);
      key_outcome_type       outcome;
      tkd_pkg::key_code_type code;
      logic                  pressed;
      pressed = (pins != tkd_pkg::PINS_RELEASED);
      if (pressed) begin
         idle_ticks = '0;
      end else begin
         idle_ticks = idle_ticks + 8'd1;
         if (idle_ticks >= debounce_limit) begin
            idle_ticks = '0;
            armed_by_release = 1'b1;
            latched_code = tkd_pkg::CODE_NONE;
         end
         stable_ticks = '0;
      end
      if (pins == tkd_pkg::PINS_FIRST) begin
         code = tkd_pkg::CODE_FIRST;
      end else if (pins == tkd_pkg::PINS_SECOND) begin
         code = tkd_pkg::CODE_SECOND;
      end else begin
         code = tkd_pkg::CODE_NONE;
      end
      if (pressed) begin
         if (code != seen_code) begin
            seen_code = code;
            stable_ticks = '0;
         end else begin
            stable_ticks = stable_ticks + 8'd1;
            if (stable_ticks >= debounce_limit) begin
               stable_ticks = '0;
               if (armed_by_release) begin
                  latched_code = code;
                  if (code != tkd_pkg::CODE_NONE) begin
                     armed_by_release = 1'b0;
                     idle_ticks = '0;
                  end
               end
            end
         end
      end
      outcome.first_taken = take_first && (latched_code == tkd_pkg::CODE_FIRST);
      if (outcome.first_taken) begin
         latched_code = tkd_pkg::CODE_NONE;
      end
      outcome.second_taken = take_second && (latched_code == tkd_pkg::CODE_SECOND);
      if (outcome.second_taken) begin
         latched_code = tkd_pkg::CODE_NONE;
      end
      outcome.held_key = latched_code;
      outcome.any_pressed = pressed;
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result word: held_key %0d", rsp_held_key);
            mismatches++;
         end else begin
            oldest_outcome = pending_outcomes.pop_front();
            if (rsp_held_key !== oldest_outcome.held_key) begin
               $error("held_key: expected %0d, actual %0d",
                      oldest_outcome.held_key, rsp_held_key);
               mismatches++;
            end
            if (rsp_any_pressed !== oldest_outcome.any_pressed) begin
               $error("any_pressed: expected %0d, actual %0d",
                      oldest_outcome.any_pressed, rsp_any_pressed);
               mismatches++;
            end
            if (rsp_first_taken !== oldest_outcome.first_taken) begin
               $error("first_taken: expected %0d, actual %0d",
                      oldest_outcome.first_taken, rsp_first_taken);
               mismatches++;
            end
            if (rsp_second_taken !== oldest_outcome.second_taken) begin
               $error("second_taken: expected %0d, actual %0d",
                      oldest_outcome.second_taken, rsp_second_taken);
               mismatches++;
            end
         end
      end
   end

   initial begin : result_drain
      int unsigned stall;
      forever begin
         stall = rsp_idling ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_word(input tkd_pkg::key_pins_type pins, input logic take_first,
                            input logic take_second);
      int unsigned gap;
      gap = req_idling ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_pins <= pins;
      req_take_first <= take_first;
      req_take_second <= take_second;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(scan_and_take(pins, take_first, take_second));
   endtask

   task automatic hold_level(input tkd_pkg::key_pins_type pins, input int unsigned ticks);
      for (int unsigned i = 0; i < ticks; i++) begin
         send_word(pins, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_debounce_ticks(input tkd_pkg::tick_count_type ticks);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {tkd_pkg::REG_DEBOUNCE_TICKS, 2'b00};
      pwdata <= {24'($urandom), ticks};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {24'd0, ticks}) begin
         $error("debounce_ticks: expected %0d, actual %0d", ticks, prdata);
         mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      debounce_limit = ticks;
   endtask

   task automatic run_key_sequences(input int unsigned words);
      int unsigned           sent;
      int unsigned           span;
      int unsigned           run;
      tkd_pkg::key_pins_type level;
      sent = 0;
      span = (debounce_limit == 0) ? 1 : debounce_limit;
      while (sent < words) begin
         req_idling = ($urandom_range(0, 3) != 0);
         rsp_idling = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            run = $urandom_range(1, 4);
            for (int unsigned i = 0; i < run; i++) begin
               send_word(tkd_pkg::key_pins_type'($urandom_range(0, 3)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            sent += run;
         end else begin
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                               : span + $urandom_range(0, 2);
            hold_level(tkd_pkg::PINS_RELEASED, run);
            sent += run;
            case ($urandom_range(0, 4))
               0, 1: begin
                  level = tkd_pkg::PINS_FIRST;
               end
               2, 3: begin
                  level = tkd_pkg::PINS_SECOND;
               end
               default: begin
                  level = PINS_BOTH;
               end
            endcase
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, span)
                                               : span + 1 + $urandom_range(0, 2);
            hold_level(level, run);
            send_word(level, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent += run + 1;
         end
      end
      wait_drained();
   endtask

   task automatic test_reset_value();
      hold_level(tkd_pkg::PINS_RELEASED, 21);
      hold_level(tkd_pkg::PINS_FIRST, 22);
      send_word(tkd_pkg::PINS_FIRST, 1'b1, 1'b0);
      wait_drained();
   endtask

   task automatic test_directed();
      write_debounce_ticks(8'd1);
      send_word(tkd_pkg::PINS_RELEASED, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_FIRST, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_FIRST, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_FIRST, 1'b1, 1'b1);
      send_word(tkd_pkg::PINS_FIRST, 1'b1, 1'b0);
      send_word(tkd_pkg::PINS_RELEASED, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b1, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b1);
      send_word(tkd_pkg::PINS_RELEASED, 1'b1, 1'b1);
      // Both pins low settles to no key while the release stays armed.
      send_word(PINS_BOTH, 1'b0, 1'b0);
      send_word(PINS_BOTH, 1'b0, 1'b0);
      send_word(PINS_BOTH, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_FIRST, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_FIRST, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_RELEASED, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b1, 1'b1);
      send_word(tkd_pkg::PINS_SECOND, 1'b1, 1'b1);
      send_word(tkd_pkg::PINS_FIRST, 1'b1, 1'b1);
      send_word(tkd_pkg::PINS_RELEASED, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_zero_debounce();
      write_debounce_ticks(8'd0);
      run_key_sequences(30);
   endtask

   task automatic test_longest_debounce();
      write_debounce_ticks(8'd255);
      req_idling = 1'b1;
      rsp_idling = 1'b0;
      hold_level(tkd_pkg::PINS_RELEASED, 255);
      wait_drained();
      write_debounce_ticks(8'd1);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b0);
      send_word(tkd_pkg::PINS_SECOND, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_settings();
      tkd_pkg::tick_count_type limits[4];
      limits[0] = 8'd1;
      limits[1] = 8'd2;
      limits[2] = 8'd3;
      limits[3] = tkd_pkg::tick_count_type'($urandom_range(4, 8));
      foreach (limits[i]) begin
         write_debounce_ticks(limits[i]);
         run_key_sequences(20);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_value();
      test_directed();
      test_zero_debounce();
      test_longest_debounce();
      test_random_settings();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* sim.f */
design/tkd_pkg.sv
design/tkd_csr.sv
design/tkd_scan.sv
design/two_key_debouncer_unit.sv
bench/two_key_debouncer_unit_tb.sv
